// ===== hw/rtl/bba_pkg.sv =====
// shared types and constants of the bitmap block allocator
package bba_pkg;

	localparam int ADDR_W = 32;
	localparam int SIZE_W = 13;
	localparam int CNT_W = 7;
	localparam int CMD_W = 2;
	localparam int CFG_IDX_W = 2;
	localparam int CFG_DATA_W = 32;

	// command codes
	localparam logic [CMD_W-1:0] CMD_ALLOC = 2'd0;
	localparam logic [CMD_W-1:0] CMD_FREE = 2'd1;
	localparam logic [CMD_W-1:0] CMD_QUERY = 2'd2;
	localparam logic [CMD_W-1:0] CMD_NOP = 2'd3;

	// configuration register indexes
	localparam logic [CFG_IDX_W-1:0] REG_BASE = 2'd0;
	localparam logic [CFG_IDX_W-1:0] REG_SIZE = 2'd1;
	localparam logic [CFG_IDX_W-1:0] REG_COUNT = 2'd2;

	localparam logic [ADDR_W-1:0] BASE_RST = 32'd0;
	localparam logic [SIZE_W-1:0] SIZE_RST = 13'd16;
	localparam logic [CNT_W-1:0] COUNT_RST = 7'd64;

	// divider retires two quotient bits per cycle
	localparam int DIV_STEPS = ADDR_W / 2;
	localparam int DIV_CW = $clog2(DIV_STEPS);

	// used-map scan width per cycle
	localparam int SCAN_W = 8;
	localparam int SCAN_LW = 3;

	typedef struct packed {
		logic start;
		logic [ADDR_W-1:0] dividend;
		logic [SIZE_W-1:0] divisor;
	} div_req_t;

	typedef struct packed {
		logic done;
		logic [ADDR_W-1:0] quotient;
	} div_rsp_t;

endpackage

// ===== hw/rtl/bba_cfg_if.sv =====
// configuration write channel
interface bba_cfg_if import bba_pkg::*;;
	logic valid;
	logic ready;
	logic [CFG_IDX_W-1:0] index;
	logic [CFG_DATA_W-1:0] data;

	modport source (output valid, output index, output data, input ready);
	modport sink (input valid, input index, input data, output ready);
endinterface

// ===== hw/rtl/bba_req_if.sv =====
// command channel into the allocator
interface bba_req_if import bba_pkg::*;;
	logic valid;
	logic ready;
	logic [CMD_W-1:0] command;
	logic [ADDR_W-1:0] address;

	modport source (output valid, output command, output address, input ready);
	modport sink (input valid, input command, input address, output ready);
endinterface

// ===== hw/rtl/bba_rsp_if.sv =====
// result channel out of the allocator
interface bba_rsp_if import bba_pkg::*;;
	logic valid;
	logic ready;
	logic [ADDR_W-1:0] block_address;
	logic ok;
	logic [CNT_W-1:0] free_blocks;

	modport source (output valid, output block_address, output ok, output free_blocks,
		input ready);
	modport sink (input valid, input block_address, input ok, input free_blocks,
		output ready);
endinterface

// ===== hw/rtl/bba_div.sv =====
// serial restoring divider, two quotient bits per cycle
module bba_div import bba_pkg::*; (
	input logic clk,
	input logic arst_n,
	input div_req_t dreq,
	output div_rsp_t drsp
);

	logic busy_q;
	logic done_q;
	logic [DIV_CW-1:0] cnt_q;
	logic [SIZE_W-1:0] div_q;
	logic [SIZE_W-1:0] rem_q;
	logic [ADDR_W-1:0] quo_q;

	logic [SIZE_W:0] r1;
	logic [SIZE_W:0] r2;
	logic b1;
	logic b2;

	// two shift-compare-subtract steps
	always_comb begin
		r1 = {rem_q, quo_q[ADDR_W-1]};
		b1 = (r1 >= {1'b0, div_q});
		if (b1) begin
			r1 = r1 - {1'b0, div_q};
		end
		r2 = {r1[SIZE_W-1:0], quo_q[ADDR_W-2]};
		b2 = (r2 >= {1'b0, div_q});
		if (b2) begin
			r2 = r2 - {1'b0, div_q};
		end
	end

	// control
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			busy_q <= 1'b0;
			done_q <= 1'b0;
			cnt_q <= '0;
		end else begin
			done_q <= !dreq.start && busy_q && (cnt_q == DIV_CW'(DIV_STEPS - 1));
			if (dreq.start) begin
				busy_q <= 1'b1;
				cnt_q <= '0;
			end else if (busy_q) begin
				cnt_q <= cnt_q + 1'b1;
				if (cnt_q == DIV_CW'(DIV_STEPS - 1)) begin
					busy_q <= 1'b0;
				end
			end
		end
	end

	// datapath
	always_ff @(posedge clk) begin
		if (dreq.start) begin
			div_q <= dreq.divisor;
			rem_q <= '0;
			quo_q <= dreq.dividend;
		end else if (busy_q) begin
			rem_q <= r2[SIZE_W-1:0];
			quo_q <= {quo_q[ADDR_W-3:0], b1, b2};
		end
	end

	assign drsp.done = done_q;
	assign drsp.quotient = quo_q;

endmodule

// ===== hw/rtl/bitmap_block_allocator_core.sv =====
// bitmap block allocator top level
//
//  channel | dir | handshake      | payload
//  cfg     | in  | valid / ready  | index, data
//  req     | in  | valid / ready  | command, address
//  rsp     | out | valid / ready  | block_address, ok, free_blocks
//
// every command scans the used map, one 8-bit slice per cycle, then finishes in
// the FIN and OUT states; free and query first pass through the serial divider
// that maps the offset to a block index
// one item is in work at a time; the next item is taken while a result still
// waits in the output register
// arst_n clears the used map and loads the register reset values
// a stalled result holds the sequencer in its last state until the slot frees
module bitmap_block_allocator_core import bba_pkg::*; #(
	parameter int MAX_BLOCKS = 64
) (
	input logic clk,
	input logic arst_n,
	bba_cfg_if.sink cfg,
	bba_req_if.sink req,
	bba_rsp_if.source rsp
);

	localparam int IW = (MAX_BLOCKS > 1) ? $clog2(MAX_BLOCKS) : 1;
	localparam int CW = $clog2(MAX_BLOCKS + 1);
	localparam int PW = (CW > CNT_W) ? CW : CNT_W;
	localparam int NCH = (MAX_BLOCKS + SCAN_W - 1) / SCAN_W;
	localparam int CHW = (NCH > 1) ? $clog2(NCH) : 1;
	localparam int PADW = NCH * SCAN_W;
	localparam int KW = CHW + SCAN_LW;
	localparam int PRODW = IW + SIZE_W;

	localparam logic [2:0] ST_IDLE = 3'd0;
	localparam logic [2:0] ST_DIV = 3'd1;
	localparam logic [2:0] ST_SCAN = 3'd2;
	localparam logic [2:0] ST_FIN = 3'd3;
	localparam logic [2:0] ST_OUT = 3'd4;

	logic [2:0] state_q;

	logic [ADDR_W-1:0] base_q;
	logic [SIZE_W-1:0] bsize_q;
	logic [CNT_W-1:0] bcount_q;
	logic [MAX_BLOCKS-1:0] used_q;

	logic [CMD_W-1:0] cmd_q;
	logic inrange_q;
	logic [IW-1:0] idx_q;
	logic [CHW-1:0] chunk_q;
	logic [CW-1:0] cnt_q;
	logic found_q;
	logic [IW-1:0] first_q;
	logic ok_q;
	logic alloc_q;
	logic [PRODW-1:0] prod_q;
	logic [CW-1:0] result_cnt_q;

	logic ovalid_q;
	logic [ADDR_W-1:0] oaddr_q;
	logic ook_q;
	logic [CNT_W-1:0] ofree_q;

	logic [PW-1:0] pool_n;
	logic [SIZE_W-1:0] psize;
	logic [PADW-1:0] used_pad;
	logic [SCAN_W-1:0] free_vec;
	logic [SCAN_LW:0] free_cnt;
	logic hit;
	logic [SCAN_LW-1:0] hit_pos;
	logic [KW-1:0] kk;
	logic [KW-1:0] first_k;
	logic idx_used;
	logic accept;
	logic slot_free;
	logic out_load;

	div_req_t dreq;
	div_rsp_t drsp;

	// effective pool count and block size
	assign pool_n = (PW'(bcount_q) > PW'(MAX_BLOCKS)) ? PW'(MAX_BLOCKS) : PW'(bcount_q);
	assign psize = (bsize_q == '0) ? SIZE_W'(1) : bsize_q;

	assign accept = req.valid && req.ready;
	assign req.ready = (state_q == ST_IDLE);
	assign cfg.ready = 1'b1;
	assign slot_free = !ovalid_q || rsp.ready;
	assign out_load = (state_q == ST_OUT) && slot_free;

	// offset division for free and query
	assign dreq.start = accept && (req.command == CMD_FREE || req.command == CMD_QUERY);
	assign dreq.dividend = req.address - base_q;
	assign dreq.divisor = psize;

	bba_div u_div (
		.clk (clk),
		.arst_n (arst_n),
		.dreq (dreq),
		.drsp (drsp)
	);

	// used map padded with taken bits to whole slices
	always_comb begin
		used_pad = '1;
		for (int p = 0; p < MAX_BLOCKS; p++) begin
			used_pad[p] = used_q[p];
		end
	end

	// one slice: free bits inside the pool, their count and the lowest one
	always_comb begin
		free_cnt = '0;
		hit = 1'b0;
		hit_pos = '0;
		kk = '0;
		for (int j = 0; j < SCAN_W; j++) begin
			kk = {chunk_q, SCAN_LW'(j)};
			free_vec[j] = !used_pad[kk] && (ADDR_W'(kk) < ADDR_W'(pool_n));
			free_cnt = free_cnt + (SCAN_LW + 1)'(free_vec[j]);
		end
		for (int j = SCAN_W - 1; j >= 0; j--) begin
			if (free_vec[j]) begin
				hit = 1'b1;
				hit_pos = SCAN_LW'(j);
			end
		end
	end

	assign first_k = {chunk_q, hit_pos};
	assign idx_used = inrange_q ? used_q[idx_q] : 1'b0;

	// configuration registers
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			base_q <= BASE_RST;
			bsize_q <= SIZE_RST;
			bcount_q <= COUNT_RST;
		end else if (cfg.valid) begin
			unique case (cfg.index)
				REG_BASE: base_q <= cfg.data;
				REG_SIZE: bsize_q <= cfg.data[SIZE_W-1:0];
				REG_COUNT: bcount_q <= cfg.data[CNT_W-1:0];
				default: ;
			endcase
		end
	end

	// sequencer and used map
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= ST_IDLE;
			used_q <= '0;
			ovalid_q <= 1'b0;
		end else begin
			if (out_load) begin
				ovalid_q <= 1'b1;
			end else if (rsp.ready) begin
				ovalid_q <= 1'b0;
			end
			unique case (state_q)
				ST_IDLE: begin
					if (accept) begin
						state_q <= dreq.start ? ST_DIV : ST_SCAN;
					end
				end
				ST_DIV: begin
					if (drsp.done) begin
						state_q <= ST_SCAN;
					end
				end
				ST_SCAN: begin
					if (chunk_q == CHW'(NCH - 1)) begin
						state_q <= ST_FIN;
					end
				end
				ST_FIN: begin
					state_q <= ST_OUT;
					unique case (cmd_q)
						CMD_ALLOC: begin
							if (found_q) begin
								used_q[first_q] <= 1'b1;
							end
						end
						CMD_FREE: begin
							if (inrange_q) begin
								used_q[idx_q] <= 1'b0;
							end
						end
						CMD_QUERY, CMD_NOP: ;
						default: ;
					endcase
				end
				ST_OUT: begin
					if (slot_free) begin
						state_q <= ST_IDLE;
					end
				end
				default: state_q <= ST_IDLE;
			endcase
		end
	end

	// item datapath
	always_ff @(posedge clk) begin
		unique case (state_q)
			ST_IDLE: begin
				cmd_q <= req.command;
				inrange_q <= 1'b0;
				idx_q <= '0;
				chunk_q <= '0;
				cnt_q <= '0;
				found_q <= 1'b0;
				first_q <= '0;
			end
			ST_DIV: begin
				if (drsp.done) begin
					inrange_q <= (drsp.quotient < ADDR_W'(pool_n));
					idx_q <= drsp.quotient[IW-1:0];
				end
			end
			ST_SCAN: begin
				chunk_q <= chunk_q + 1'b1;
				cnt_q <= cnt_q + CW'(free_cnt);
				if (hit && !found_q) begin
					found_q <= 1'b1;
					first_q <= first_k[IW-1:0];
				end
			end
			ST_FIN: begin
				prod_q <= PRODW'(first_q) * PRODW'(psize);
				alloc_q <= (cmd_q == CMD_ALLOC) && found_q;
				unique case (cmd_q)
					CMD_ALLOC: begin
						ok_q <= found_q;
						result_cnt_q <= found_q ? (cnt_q - 1'b1) : cnt_q;
					end
					CMD_FREE: begin
						ok_q <= inrange_q;
						result_cnt_q <= inrange_q ? (cnt_q + CW'(idx_used)) : cnt_q;
					end
					CMD_QUERY: begin
						ok_q <= idx_used;
						result_cnt_q <= cnt_q;
					end
					CMD_NOP: begin
						ok_q <= 1'b0;
						result_cnt_q <= cnt_q;
					end
					default: ;
				endcase
			end
			ST_OUT: begin
				if (slot_free) begin
					oaddr_q <= alloc_q ? (base_q + ADDR_W'(prod_q)) : '0;
					ook_q <= ok_q;
					ofree_q <= CNT_W'(result_cnt_q);
				end
			end
			default: ;
		endcase
	end

	// result register
	assign rsp.valid = ovalid_q;
	assign rsp.block_address = oaddr_q;
	assign rsp.ok = ook_q;
	assign rsp.free_blocks = ofree_q;

endmodule

// ===== hw/rtl/bba_checker.sv =====
// port checker for the bitmap block allocator and its bind
module bba_checker import bba_pkg::*; #(
	parameter int MAX_BLOCKS = 64
) (
	input logic clk,
	input logic arst_n,
	input logic req_valid,
	input logic req_ready,
	input logic rsp_valid,
	input logic rsp_ready,
	input logic [ADDR_W-1:0] rsp_block_address,
	input logic rsp_ok,
	input logic [CNT_W-1:0] rsp_free_blocks,
	input logic cfg_ready
);

	// a stalled result keeps its payload
	a_rsp_hold: assert property (@(posedge clk) disable iff (!arst_n)
		rsp_valid && !rsp_ready |=> rsp_valid && $stable(rsp_block_address)
			&& $stable(rsp_ok) && $stable(rsp_free_blocks))
		else $error("result changed while stalled");

	// one item in work at a time
	a_one_item: assert property (@(posedge clk) disable iff (!arst_n)
		req_valid && req_ready |=> !req_ready)
		else $error("item taken while busy");

	// free count never exceeds the pool capacity
	a_free_bound: assert property (@(posedge clk) disable iff (!arst_n)
		rsp_valid |-> (32'(rsp_free_blocks) <= MAX_BLOCKS))
		else $error("free count above capacity");

	// failed allocation or free/query results carry a zero address unless ok
	a_addr_zero: assert property (@(posedge clk) disable iff (!arst_n)
		rsp_valid && !rsp_ok |-> (rsp_block_address == '0))
		else $error("address on a failed result");

	// configuration writes are always taken
	a_cfg_ready: assert property (@(posedge clk) disable iff (!arst_n) cfg_ready)
		else $error("configuration port stalled");

endmodule

bind bitmap_block_allocator_core bba_checker #(.MAX_BLOCKS(MAX_BLOCKS)) u_bba_checker (
	.clk (clk),
	.arst_n (arst_n),
	.req_valid (req.valid),
	.req_ready (req.ready),
	.rsp_valid (rsp.valid),
	.rsp_ready (rsp.ready),
	.rsp_block_address (rsp.block_address),
	.rsp_ok (rsp.ok),
	.rsp_free_blocks (rsp.free_blocks),
	.cfg_ready (cfg.ready)
);

// ===== sim/testbench.sv =====
// self-checking testbench for the bitmap block allocator top level
module testbench;
	import bba_pkg::*;

	localparam int MAX_BLOCKS = 64;
	localparam int unsigned CYCLE_LIMIT = 400000;

	typedef struct packed {
		logic [ADDR_W-1:0] block_address;
		logic ok;
		logic [CNT_W-1:0] free_blocks;
	} alloc_result_t;

	// pool state mirror and the queue of results it predicts
	class pool_tracker;
		logic [ADDR_W-1:0] base;
		logic [SIZE_W-1:0] bsize;
		logic [CNT_W-1:0] bcount;
		logic [MAX_BLOCKS-1:0] used;
		alloc_result_t pending_results[$];
		int unsigned errors;

		function new();
			base = BASE_RST;
			bsize = SIZE_RST;
			bcount = COUNT_RST;
			used = '0;
			errors = 0;
		endfunction

		function int unsigned pool_blocks();
			return (bcount > MAX_BLOCKS) ? MAX_BLOCKS : bcount;
		endfunction

		// a zero size behaves as one byte
		function logic [ADDR_W-1:0] block_bytes();
			return (bsize == 0) ? 1 : ADDR_W'(bsize);
		endfunction

		function logic [CNT_W-1:0] count_free();
			logic [CNT_W-1:0] n;
			n = 0;
			for (int unsigned i = 0; i < pool_blocks(); i++)
				if (!used[i])
					n++;
			return n;
		endfunction

		// offset wraps modulo 2^32, so addresses below base land out of range
		function bit locate(input logic [ADDR_W-1:0] addr, output int unsigned idx);
			logic [ADDR_W-1:0] q;
			q = (addr - base) / block_bytes();
			idx = q;
			return q < pool_blocks();
		endfunction

		function void set_register(logic [CFG_IDX_W-1:0] idx, logic [CFG_DATA_W-1:0] value);
			case (idx)
			REG_BASE: base = value[ADDR_W-1:0];
			REG_SIZE: bsize = value[SIZE_W-1:0];
			REG_COUNT: bcount = value[CNT_W-1:0];
			default: ;
			endcase
		endfunction

		// apply one accepted command and queue the result it should produce
		function void take_command(logic [CMD_W-1:0] cmd, logic [ADDR_W-1:0] addr);
			alloc_result_t r;
			int unsigned idx;
			r = '0;
			idx = 0;
			case (cmd)
			CMD_ALLOC: begin
				while (idx < pool_blocks() && used[idx])
					idx++;
				if (idx < pool_blocks()) begin
					used[idx] = 1'b1;
					r.block_address = base + ADDR_W'(idx) * block_bytes();
					r.ok = 1'b1;
				end
			end
			CMD_FREE: begin
				if (locate(addr, idx)) begin
					used[idx] = 1'b0;
					r.ok = 1'b1;
				end
			end
			CMD_QUERY: begin
				if (locate(addr, idx))
					r.ok = used[idx];
			end
			default: ;
			endcase
			r.free_blocks = count_free();
			pending_results.push_back(r);
		endfunction

		function void flag(string what, logic [ADDR_W-1:0] want, logic [ADDR_W-1:0] got);
			errors++;
			$display("%0t: %s mismatch, expected %h actual %h", $time, what, want, got);
		endfunction

		function void check_result(logic [ADDR_W-1:0] addr, logic ok, logic [CNT_W-1:0] nfree);
			alloc_result_t want;
			if (pending_results.size() == 0) begin
				errors++;
				$display("%0t: unexpected result, expected none actual %h %b %0d",
					$time, addr, ok, nfree);
			end else begin
				want = pending_results.pop_front();
				if (addr !== want.block_address)
					flag("block_address", want.block_address, addr);
				if (ok !== want.ok)
					flag("ok", ADDR_W'(want.ok), ADDR_W'(ok));
				if (nfree !== want.free_blocks)
					flag("free_blocks", ADDR_W'(want.free_blocks), ADDR_W'(nfree));
			end
		endfunction

		function int unsigned pending();
			return pending_results.size();
		endfunction
	endclass

	logic clk;
	logic arst_n;

	bba_cfg_if cfg_ch();
	bba_req_if req_ch();
	bba_rsp_if rsp_ch();

	pool_tracker tracker = new();

	int unsigned cycles;
	int unsigned stall_mode;
	logic [15:0] stall_pat;

	bitmap_block_allocator_core #(
		.MAX_BLOCKS(MAX_BLOCKS)
	) u_top (
		.clk(clk),
		.arst_n(arst_n),
		.cfg(cfg_ch),
		.req(req_ch),
		.rsp(rsp_ch)
	);

	// clock
	always begin
		clk = 1'b0;
		#4;
		clk = 1'b1;
		#4;
	end

	// result side: check accepted items, stall on a changing pattern, watchdog
	always @(posedge clk) begin
		cycles++;
		if (arst_n && rsp_ch.valid && rsp_ch.ready)
			tracker.check_result(rsp_ch.block_address, rsp_ch.ok, rsp_ch.free_blocks);
		if (cycles % 300 == 0) begin
			stall_mode = $urandom_range(0, 3);
			stall_pat = 16'($urandom()) | 16'h1;
		end else begin
			stall_pat = {stall_pat[0], stall_pat[15:1]};
		end
		case (stall_mode)
		0: rsp_ch.ready <= 1'b1;
		1: rsp_ch.ready <= stall_pat[0];
		2: rsp_ch.ready <= 1'($urandom_range(0, 1));
		default: rsp_ch.ready <= ($urandom_range(0, 9) == 0);
		endcase
		if (cycles >= CYCLE_LIMIT) begin
			$display("FAIL bitmap_block_allocator_core");
			$finish;
		end
	end

	// present one item and hold it until taken; valid stays high afterwards
	task automatic push_item(input logic [CMD_W-1:0] cmd, input logic [ADDR_W-1:0] addr);
		req_ch.valid <= 1'b1;
		req_ch.command <= cmd;
		req_ch.address <= addr;
		do @(posedge clk); while (!req_ch.ready);
		tracker.take_command(cmd, addr);
	endtask

	task automatic pause(input int unsigned n);
		if (n > 0) begin
			req_ch.valid <= 1'b0;
			repeat (n) @(posedge clk);
		end
	endtask

	// stop sending and wait until every result is back
	task automatic settle();
		req_ch.valid <= 1'b0;
		@(posedge clk);
		while (tracker.pending() != 0)
			@(posedge clk);
		repeat (4) @(posedge clk);
	endtask

	task automatic write_reg(input logic [CFG_IDX_W-1:0] idx, input logic [CFG_DATA_W-1:0] value);
		cfg_ch.valid <= 1'b1;
		cfg_ch.index <= idx;
		cfg_ch.data <= value;
		do @(posedge clk); while (!cfg_ch.ready);
		tracker.set_register(idx, value);
		cfg_ch.valid <= 1'b0;
		@(posedge clk);
	endtask

	// mostly addresses inside the pool, some past its end, below base or anywhere
	function automatic logic [ADDR_W-1:0] pick_address();
		int unsigned sel;
		int unsigned n;
		logic [ADDR_W-1:0] u;
		sel = $urandom_range(0, 99);
		n = tracker.pool_blocks();
		u = tracker.block_bytes();
		if (sel < 70 && n > 0)
			return tracker.base + ADDR_W'($urandom_range(0, n - 1)) * u
				+ ADDR_W'($urandom_range(0, u - 1));
		else if (sel < 80)
			return tracker.base + ADDR_W'(n) * u + ADDR_W'($urandom_range(0, u - 1));
		else if (sel < 88)
			return tracker.base - ADDR_W'($urandom_range(1, 4 * u));
		else if (sel < 95)
			return $urandom();
		else
			return ($urandom_range(0, 1) != 0) ? '1 : '0;
	endfunction

	// new pool setting, then random traffic sent in bursts
	task automatic run_phase(input logic [ADDR_W-1:0] base, input int unsigned bsize,
		input int unsigned bcount, input int unsigned items, input int unsigned alloc_pct);
		int unsigned burst_left;
		int unsigned sel;
		int unsigned free_top;
		settle();
		write_reg(REG_BASE, base);
		write_reg(REG_SIZE, CFG_DATA_W'(bsize));
		write_reg(REG_COUNT, CFG_DATA_W'(bcount));
		burst_left = 0;
		free_top = alloc_pct + (94 - alloc_pct) / 2;
		repeat (items) begin
			if (burst_left == 0) begin
				burst_left = $urandom_range(1, 16);
				pause(($urandom_range(0, 3) == 0) ? 0 : $urandom_range(1, 30));
			end
			burst_left--;
			sel = $urandom_range(0, 99);
			if (sel < alloc_pct)
				push_item(CMD_ALLOC, $urandom());
			else if (sel < free_top)
				push_item(CMD_FREE, pick_address());
			else if (sel < 94)
				push_item(CMD_QUERY, pick_address());
			else if (sel < 97)
				push_item(CMD_NOP, $urandom());
			else
				push_item(CMD_W'($urandom()), pick_address());
		end
	endtask

	initial begin
		arst_n = 1'b0;
		cfg_ch.valid = 1'b0;
		cfg_ch.index = REG_BASE;
		cfg_ch.data = '0;
		req_ch.valid = 1'b0;
		req_ch.command = CMD_NOP;
		req_ch.address = '0;
		rsp_ch.ready = 1'b0;
		cycles = 0;
		stall_mode = 0;
		stall_pat = 16'hA5C3;
		repeat (11) @(posedge clk);
		arst_n <= 1'b1;
		repeat (2) @(posedge clk);

		// reset setting: lowest free block, in-block addresses, double free, range ends
		push_item(CMD_QUERY, 32'h0000_0000);
		push_item(CMD_ALLOC, 32'hFFFF_FFFF);
		push_item(CMD_ALLOC, 32'h0000_0000);
		push_item(CMD_QUERY, 32'h0000_001F);
		push_item(CMD_FREE, 32'h0000_0005);
		push_item(CMD_FREE, 32'h0000_0005);
		push_item(CMD_ALLOC, 32'h0000_0000);
		push_item(CMD_FREE, 32'h0000_0400);
		push_item(CMD_QUERY, 32'hFFFF_FFFF);
		push_item(CMD_NOP, 32'hFFFF_FFFF);
		push_item(CMD_QUERY, 32'h0000_03F0);
		push_item(CMD_FREE, 32'h0000_03FF);

		// zero block size, base near the top, tiny pool that fills up
		settle();
		write_reg(REG_BASE, 32'hFFFF_FFF0);
		write_reg(REG_SIZE, 32'd0);
		write_reg(REG_COUNT, 32'd3);
		push_item(CMD_ALLOC, 32'h0000_0000);
		push_item(CMD_ALLOC, 32'h0000_0000);
		push_item(CMD_QUERY, 32'hFFFF_FFF1);
		push_item(CMD_FREE, 32'hFFFF_FFEF);
		push_item(CMD_QUERY, 32'hFFFF_FFF3);

		// empty pool
		settle();
		write_reg(REG_COUNT, 32'd0);
		push_item(CMD_ALLOC, 32'h0000_0000);
		push_item(CMD_FREE, 32'hFFFF_FFF0);
		push_item(CMD_QUERY, 32'hFFFF_FFF0);

		// oversized count saturates, kept used bits come back, wrapped alloc address
		settle();
		write_reg(REG_COUNT, 32'd127);
		write_reg(REG_SIZE, 32'd8191);
		push_item(CMD_QUERY, 32'hFFFF_FFF0);
		push_item(CMD_ALLOC, 32'h0000_0000);

		// random traffic over a spread of pool settings
		run_phase(32'h0000_0000, 16, 64, 180, 55);
		run_phase(32'hFFFF_FF00, 4096, 64, 120, 60);
		run_phase($urandom(), 1, 1, 60, 45);
		run_phase(32'h8000_0000 | $urandom(), 0, 127, 120, 60);
		run_phase($urandom(), 24, 5, 80, 50);
		run_phase(tracker.base, 24, 64, 80, 40);
		run_phase(32'hFFFF_FFFF, 8191, 64, 100, 55);
		run_phase($urandom(), 16, 0, 30, 40);
		repeat (3)
			run_phase($urandom(), $urandom_range(1, 4096), $urandom_range(1, 64), 60, 50);

		settle();
		repeat (40) @(posedge clk);
		if (tracker.errors == 0 && tracker.pending() == 0)
			$display("PASS bitmap_block_allocator_core");
		else
			$display("FAIL bitmap_block_allocator_core");
		$finish;
	end

endmodule
